// ===== src/fa_lru_pkg.sv =====
// Shared types and constants for the fully associative LRU tag store.
package fa_lru_pkg;

    // Width and reset value of the capacity register.
    localparam int          CAP_W     = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Command codes carried on the input channel.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_FILL   = 1'b1;

    // Sequencer states of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_UPDATE
    } fa_lru_state_t;

    // Per-cell control issued by the sequencer.
    typedef struct packed {
        logic compare_en;
        logic shift_en;
    } fa_lru_cell_ctl_t;

endpackage

// ===== src/fa_lru_cell.sv =====
// One cell of the recency-ordered tag chain: holds a tag, a valid bit and a match flag.
module fa_lru_cell
    import fa_lru_pkg::*;
#(
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  fa_lru_cell_ctl_t        ctl,
    input  logic [ADDRESS_BITS-1:0] key,
    input  logic [ADDRESS_BITS-1:0] prev_tag,
    input  logic                    prev_valid,
    output logic [ADDRESS_BITS-1:0] tag,
    output logic                    valid,
    output logic                    match
);

    logic [ADDRESS_BITS-1:0] tag_reg;
    logic [ADDRESS_BITS-1:0] tag_next;
    logic                    valid_reg;
    logic                    valid_next;
    logic                    match_reg;
    logic                    match_next;

    always_comb
    begin
        tag_next   = tag_reg;
        valid_next = valid_reg;
        match_next = match_reg;
        if (ctl.compare_en)
        begin
            match_next = valid_reg && (tag_reg == key);
        end
        // The cell takes its neighbour's line when the chain moves down.
        if (ctl.shift_en)
        begin
            tag_next   = prev_tag;
            valid_next = prev_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    assign tag   = tag_reg;
    assign valid = valid_reg;
    assign match = match_reg;

endmodule

// ===== src/fully_associative_lru_tag_store.sv =====
// Top level of the fully associative tag store with least-recently-used replacement.
//
// Input channel: command (lookup or fill) and line_address, with in_valid and in_stall.
// A transaction is taken at a rising edge where in_valid is high and in_stall is low.
// Output channel: hit, evicted_valid, evicted_address and occupancy, with out_valid
// and out_stall; exactly one result transaction leaves for every input transaction.
// The capacity register is written through cfg_write_en and capacity_lines; the
// user must write it only while the block is idle, which the block itself does
// not enforce; a value of zero acts as one and values above MAX_LINES are clipped.
// Each item has a compare step, which compares the key against every cell of the
// chain, and an update step, which moves the chain and loads the result register;
// the next item can be taken as the update completes, but not during the compare.
// The lines sit in a chain of cells ordered by recency: cell 0 holds the most
// recent line and the valid cells always form an unbroken run from cell 0, so the
// least recent line is the last valid cell.
// After reset every cell is empty, the line count is zero and the capacity is 64.
// While out_stall holds a finished result, the block keeps that result in its
// output register; an item that reaches its update step waits there and raises
// in_stall until the result can be replaced.
module fully_associative_lru_tag_store
    import fa_lru_pkg::*;
#(
    parameter int MAX_LINES    = 64,
    parameter int ADDRESS_BITS = 48
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [CAP_W-1:0]                    capacity_lines,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [ADDRESS_BITS-1:0]             line_address,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                hit,
    output logic                                evicted_valid,
    output logic [ADDRESS_BITS-1:0]             evicted_address,
    output logic [$clog2(MAX_LINES+1)-1:0]      occupancy
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Sequencer and item registers.
    fa_lru_state_t           state_reg;
    fa_lru_state_t           state_next;
    logic                    cmd_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [CAP_W-1:0]        cap_reg;

    // Result register.
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    hit_reg;
    logic                    ev_valid_reg;
    logic [ADDRESS_BITS-1:0] ev_addr_reg;
    logic [CNT_W-1:0]        occ_reg;

    // Cell chain.
    fa_lru_cell_ctl_t        cell_ctl   [MAX_LINES];
    logic [ADDRESS_BITS-1:0] cell_tag   [MAX_LINES];
    logic [MAX_LINES-1:0]    cell_valid;
    logic [MAX_LINES-1:0]    cell_match;
    logic [MAX_LINES-1:0]    cell_last;

    // Update step decisions.
    logic                    can_emit;
    logic                    in_accept;
    logic                    update_fire;
    logic                    any_hit;
    logic                    is_fill;
    logic                    do_evict;
    logic                    do_shift;
    logic [CNT_W-1:0]        hit_pos;
    logic [CNT_W-1:0]        last_pos;
    logic [CMP_W-1:0]        eff_cap;
    logic [ADDRESS_BITS-1:0] victim_tag;

    assign can_emit    = !out_valid_reg || !out_stall;
    assign in_stall    = !((state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && can_emit));
    assign in_accept   = in_valid && !in_stall;
    assign update_fire = (state_reg == ST_UPDATE) && can_emit;

    // Out-of-range capacity values are folded into the legal range.
    always_comb
    begin
        eff_cap = CMP_W'(cap_reg);
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(MAX_LINES))
        begin
            eff_cap = CMP_W'(MAX_LINES);
        end
    end

    // The tags are unique, so at most one cell matches and its position is an
    // OR of the indices of the matching cells.
    always_comb
    begin
        hit_pos = '0;
        for (int k = 0; k < MAX_LINES; k++)
        begin
            hit_pos = hit_pos | (cell_match[k] ? CNT_W'(k) : '0);
        end
    end

    assign any_hit  = |cell_match;
    assign is_fill  = (cmd_reg == CMD_FILL);
    assign do_evict = is_fill && !any_hit && (CMP_W'(count_reg) >= eff_cap);
    assign do_shift = any_hit || is_fill;

    // Cells 0 to last_pos move down by one and cell 0 takes the item's
    // line. A hit closes the gap it leaves; an insert grows the run by one;
    // an eviction overwrites the least recent cell.
    always_comb
    begin
        if (any_hit)
        begin
            last_pos = hit_pos;
        end
        else if (do_evict)
        begin
            last_pos = count_reg - CNT_W'(1);
        end
        else
        begin
            last_pos = count_reg;
        end
    end

    // The least recent line is the valid cell whose neighbour below is empty.
    always_comb
    begin
        victim_tag = '0;
        for (int k = 0; k < MAX_LINES; k++)
        begin
            victim_tag = victim_tag | (cell_tag[k] & {ADDRESS_BITS{cell_last[k]}});
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_LINES; g++)
        begin : g_cell
            if (g == MAX_LINES - 1)
            begin : g_tail
                assign cell_last[g] = cell_valid[g];
            end
            else
            begin : g_body
                assign cell_last[g] = cell_valid[g] && !cell_valid[g+1];
            end

            assign cell_ctl[g].compare_en = (state_reg == ST_COMPARE);
            assign cell_ctl[g].shift_en   = update_fire && do_shift &&
                                            (CNT_W'(g) <= last_pos);

            if (g == 0)
            begin : g_head
                fa_lru_cell #(
                    .ADDRESS_BITS(ADDRESS_BITS)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (cell_ctl[g]),
                    .key       (addr_reg),
                    .prev_tag  (addr_reg),
                    .prev_valid(1'b1),
                    .tag       (cell_tag[g]),
                    .valid     (cell_valid[g]),
                    .match     (cell_match[g])
                );
            end
            else
            begin : g_link
                fa_lru_cell #(
                    .ADDRESS_BITS(ADDRESS_BITS)
                ) u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctl       (cell_ctl[g]),
                    .key       (addr_reg),
                    .prev_tag  (cell_tag[g-1]),
                    .prev_valid(cell_valid[g-1]),
                    .tag       (cell_tag[g]),
                    .valid     (cell_valid[g]),
                    .match     (cell_match[g])
                );
            end
        end
    endgenerate

    // Sequencer: compare, then update; a new transaction may be taken in the
    // same cycle as the update completes.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (update_fire)
                begin
                    out_valid_next = 1'b1;
                    if (is_fill && !any_hit && !do_evict)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = in_accept ? ST_COMPARE : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                cap_reg <= capacity_lines;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= command;
            addr_reg <= line_address;
        end
        if (update_fire)
        begin
            hit_reg      <= any_hit;
            ev_valid_reg <= do_evict;
            ev_addr_reg  <= do_evict ? victim_tag : '0;
            occ_reg      <= count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_address = ev_addr_reg;
    assign occupancy       = occ_reg;

endmodule

// ===== src/fa_lru_chk.sv =====
// Port-level checker for the fully associative LRU tag store, with its bind.
module fa_lru_chk
    import fa_lru_pkg::*;
#(
    parameter int MAX_LINES    = 64,
    parameter int ADDRESS_BITS = 48
)
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           hit,
    input logic                           evicted_valid,
    input logic [ADDRESS_BITS-1:0]        evicted_address,
    input logic [$clog2(MAX_LINES+1)-1:0] occupancy
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);

    // A result held by the receiver stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(evicted_valid)
            && $stable(evicted_address) && $stable(occupancy))
        else $error("stalled result transaction changed");

    // Each accepted transaction occupies the block for its compare step.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("transaction accepted during compare step");

    // An eviction is never reported together with a hit.
    a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted_valid |-> !hit)
        else $error("eviction reported together with a hit");

    // The evicted address reads zero when nothing was evicted.
    a_evict_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_address == '0)
        else $error("evicted address not zero without eviction");

    // Occupancy never exceeds the number of cells.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_W'(MAX_LINES))
        else $error("occupancy beyond the number of lines");

endmodule

bind fully_associative_lru_tag_store fa_lru_chk #(
    .MAX_LINES   (MAX_LINES),
    .ADDRESS_BITS(ADDRESS_BITS)
) u_fa_lru_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .evicted_valid  (evicted_valid),
    .evicted_address(evicted_address),
    .occupancy      (occupancy)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the fully associative LRU tag store.
module tb_top;

    import fa_lru_pkg::*;

    localparam int MAX_LINES    = 64;
    localparam int ADDR_W       = 48;
    localparam int OCC_W        = $clog2(MAX_LINES + 1);
    // Calm that is allowed once every result is back, before the capacity register
    // is touched or the run is closed.
    localparam int QUIET_CYCLES = 4;

    // One result transaction as the block should present it.
    typedef struct {
        logic              hit;
        logic              evicted_valid;
        logic [ADDR_W-1:0] evicted_address;
        logic [OCC_W-1:0]  occupancy;
    } tag_outcome_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_write_en;
    logic [CAP_W-1:0]  capacity_lines;
    logic              in_valid;
    logic              in_stall;
    logic              command;
    logic [ADDR_W-1:0] line_address;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              hit;
    logic              evicted_valid;
    logic [ADDR_W-1:0] evicted_address;
    logic [OCC_W-1:0]  occupancy;

    // Predictor state: the resident lines ordered by recency, most recent
    // first, and our own copy of the capacity register.
    logic [ADDR_W-1:0] recency_order[$];
    logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

    // Outcomes predicted for accepted transactions, oldest first.
    tag_outcome_t      predicted_outcomes[$];

    // Addresses that the random traffic draws from, so that hits and
    // evictions happen often.
    logic [ADDR_W-1:0] address_pool[$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int mismatch_count = 0;

    fully_associative_lru_tag_store #(
        .MAX_LINES    (MAX_LINES),
        .ADDRESS_BITS (ADDR_W)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .capacity_lines  (capacity_lines),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .line_address    (line_address),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .hit             (hit),
        .evicted_valid   (evicted_valid),
        .evicted_address (evicted_address),
        .occupancy       (occupancy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // A zero capacity behaves as one line and anything above the array size
    // is clipped to the array size.
    function automatic int effective_lines(input logic [CAP_W-1:0] cap);
        if (cap == 0)
        begin
            return 1;
        end
        if (cap > MAX_LINES)
        begin
            return MAX_LINES;
        end
        return int'(cap);
    endfunction

    // Applies one lookup or fill to the predicted tag store and returns the
    // outcome that the block must report for it.
    function automatic tag_outcome_t apply_access(input logic cmd,
                                                  input logic [ADDR_W-1:0] addr);
        tag_outcome_t outcome;
        int           pos;
        outcome = '{default: '0};
        pos = -1;
        for (int i = 0; i < recency_order.size(); i++)
        begin
            if (recency_order[i] == addr)
            begin
                pos = i;
            end
        end
        if (pos >= 0)
        begin
            // A hit, whether by lookup or by fill, only moves the line to
            // the most recent position.
            outcome.hit = 1'b1;
            recency_order.delete(pos);
            recency_order.push_front(addr);
        end
        else if (cmd == CMD_FILL)
        begin
            // When full, or over-full after the capacity was lowered, exactly
            // one line leaves: the least recent, at the back of the list.
            if (recency_order.size() >= effective_lines(capacity_setting))
            begin
                outcome.evicted_valid   = 1'b1;
                outcome.evicted_address = recency_order.pop_back();
            end
            recency_order.push_front(addr);
        end
        // A missing lookup leaves everything untouched.
        outcome.occupancy = OCC_W'(recency_order.size());
        return outcome;
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        case ($urandom_range(15, 0))
            0:       return '0;
            1:       return '1;
            default: return ADDR_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offers one transaction and holds it until the block takes it. Valid is
    // left high on acceptance; whoever pauses next is responsible for
    // lowering it, so it is never dropped and raised in the same step.
    task automatic issue_access(input logic cmd, input logic [ADDR_W-1:0] addr);
        tag_outcome_t outcome;
        while ($urandom_range(99, 0) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        line_address <= addr;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        outcome = apply_access(cmd, addr);
        predicted_outcomes = {predicted_outcomes, outcome};
    endtask

    // Stops offering transactions, waits for every predicted result to come
    // back and then lets the pipeline settle.
    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        while (predicted_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // The capacity register is only written once the block has gone quiet.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_for_quiet();
        cfg_write_en   <= 1'b1;
        capacity_lines <= cap;
        @(posedge clk);
        cfg_write_en     <= 1'b0;
        capacity_setting  = cap;
    endtask

    // After reset nothing is resident, so lookups at both address extremes
    // must miss with an empty store.
    task automatic test_empty_lookups();
        issue_access(CMD_LOOKUP, '0);
        issue_access(CMD_LOOKUP, '1);
    endtask

    // Fills, hits by lookup, and a fill of a line that is already resident,
    // which must only promote it. The sender also pauses here until every
    // outstanding result has been returned.
    task automatic test_fill_and_promote();
        issue_access(CMD_FILL, '0);
        issue_access(CMD_FILL, '1);
        issue_access(CMD_LOOKUP, '0);
        issue_access(CMD_FILL, '1);
        wait_for_quiet();
        issue_access(CMD_LOOKUP, 48'h1234_5678_9abc);
        issue_access(CMD_FILL, 48'h1234_5678_9abc);
    endtask

    // Lowers the capacity beneath the occupancy, where each missing fill
    // swaps one line for another, then tries the zero setting and finally a
    // small capacity where a promoted line must survive an eviction.
    task automatic test_capacity_limits();
        write_capacity(7'd1);
        issue_access(CMD_FILL, 48'h0000_0000_00a1);
        issue_access(CMD_LOOKUP, 48'h0000_0000_00a2);
        issue_access(CMD_FILL, 48'h8000_0000_00b1);
        write_capacity(7'd0);
        issue_access(CMD_FILL, 48'h5555_5555_5555);
        issue_access(CMD_FILL, 48'haaaa_aaaa_aaaa);
        write_capacity(7'd4);
        issue_access(CMD_FILL, 48'h0000_0000_0c01);
        issue_access(CMD_FILL, 48'h0000_0000_0c02);
        issue_access(CMD_LOOKUP, 48'h5555_5555_5555);
        issue_access(CMD_FILL, 48'h0000_0000_0c03);
        issue_access(CMD_FILL, 48'h0000_0000_0c04);
        issue_access(CMD_LOOKUP, 48'h5555_5555_5555);
    endtask

    // Random lookups and fills under one capacity. Most addresses come from a
    // pool somewhat larger than the capacity, so the store fills, hits and
    // evicts; the rest are fresh addresses that almost always miss.
    task automatic run_random_traffic(input int n_items, input logic [CAP_W-1:0] cap);
        int                pool_size;
        logic [ADDR_W-1:0] addr;
        logic              cmd;
        write_capacity(cap);
        pool_size = effective_lines(cap) + effective_lines(cap) / 2 + 2;
        address_pool.delete();
        repeat (pool_size) address_pool = {address_pool, random_address()};
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(63, 0) == 0)
            begin
                wait_for_quiet();
            end
            if ($urandom_range(9, 0) == 0)
            begin
                addr = random_address();
            end
            else
            begin
                addr = address_pool[$urandom_range(pool_size - 1, 0)];
            end
            cmd = ($urandom_range(1, 0) == 1) ? CMD_FILL : CMD_LOOKUP;
            issue_access(cmd, addr);
        end
    endtask

    // Result checker and receiver back-pressure. The outputs and out_stall
    // are read as they stood at the clock edge, before this step's update of
    // out_stall takes effect.
    always @(posedge clk)
    begin : result_checker
        tag_outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_outcomes.size() == 0)
            begin
                flag_mismatch("unexpected result transaction", 64'd1, 64'd0);
            end
            else
            begin
                want = predicted_outcomes[0];
                predicted_outcomes.delete(0);
                if (hit !== want.hit)
                begin
                    flag_mismatch("hit", 64'(hit), 64'(want.hit));
                end
                if (evicted_valid !== want.evicted_valid)
                begin
                    flag_mismatch("evicted_valid", 64'(evicted_valid),
                                  64'(want.evicted_valid));
                end
                if (evicted_address !== want.evicted_address)
                begin
                    flag_mismatch("evicted_address", 64'(evicted_address),
                                  64'(want.evicted_address));
                end
                if (occupancy !== want.occupancy)
                begin
                    flag_mismatch("occupancy", 64'(occupancy), 64'(want.occupancy));
                end
            end
        end
        out_stall <= ($urandom_range(99, 0) < receiver_idle_pct);
    end

    initial
    begin
        rst_n          <= 1'b0;
        cfg_write_en   <= 1'b0;
        capacity_lines <= CAP_RESET;
        in_valid       <= 1'b0;
        command        <= CMD_LOOKUP;
        line_address   <= '0;

        // First phase: a mostly eager sender against a slow receiver.
        sender_idle_pct   = 13;
        receiver_idle_pct = 68;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookups();
        test_fill_and_promote();
        test_capacity_limits();
        run_random_traffic(350, 7'd64);
        run_random_traffic(200, 7'd3);

        // Second phase: a hesitant sender against an eager receiver.
        wait_for_quiet();
        sender_idle_pct   = 68;
        receiver_idle_pct = 13;
        run_random_traffic(350, 7'd127);
        run_random_traffic(250, CAP_W'($urandom_range(63, 2)));

        // Final phase: both sides at full speed.
        wait_for_quiet();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_traffic(150, 7'd0);
        run_random_traffic(250, CAP_W'($urandom_range(63, 2)));
        run_random_traffic(350, 7'd64);

        wait_for_quiet();
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    // Guards against a hung handshake.
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
